[sv/psx_pkg.sv]
// Shared constants and types for the printable string extractor.
// No dependencies; the top, front, back and request queue files import this package.
`timescale 1ns / 1ps
`default_nettype none
package psx_pkg;

	localparam int MAX_LEN = 64;
	localparam int RUN_SAT = (MAX_LEN >= 255) ? (MAX_LEN + 1) : 255;
	localparam int RUN_W   = $clog2(RUN_SAT + 1);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int ADDR_W  = IDX_W + 1;
	localparam int RAM_DEPTH = 2 ** ADDR_W;
	localparam int PADDR_W = 3;

	localparam logic [RUN_W-1:0] MAX_LEN_R = RUN_W'(MAX_LEN);
	localparam logic [RUN_W-1:0] RUN_SAT_R = RUN_W'(RUN_SAT);

	localparam logic [7:0] NUL_BYTE   = 8'h00;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] MIN_LENGTH_RESET = 8'd3;

	localparam logic REG_MIN_LENGTH = 1'b0;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] cnt;
		logic             trunc;
	} psx_cmd_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} psx_release_t;

endpackage
`default_nettype wire

[sv/psx_if.sv]
// Request channel interfaces: input bytes and extracted characters.
// Depends on nothing but the ready/valid convention.
`timescale 1ns / 1ps
`default_nettype none
interface psx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       section_last;

	modport source (output valid, output data_byte, output section_last, input ready);
	modport sink (input valid, input data_byte, input section_last, output ready);
endinterface

interface psx_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       string_last;
	logic       truncated;

	modport source (output valid, output out_char, output string_last, output truncated,
		input ready);
	modport sink (input valid, input out_char, input string_last, input truncated,
		output ready);
endinterface
`default_nettype wire

[sv/printable_string_extractor.sv]
// Printable string extractor: one input byte per cycle while the fill bank is free.
// A string's first character appears after its closing NUL is accepted and queued as a request,
// then one character per cycle, limited by the buffer RAM read port and output stall.
// Input stalls only when both buffer banks hold strings still being read out.
// Reset clears the scan state, frees both banks and sets min_length to 3; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module printable_string_extractor (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	psx_in_if.sink                          in_ch,
	psx_out_if.source                       out_ch,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [psx_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import psx_pkg::*;

	logic [7:0] min_length_q;
	logic       reg_sel;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [6:0]        wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic [6:0]        rdata;
	logic              push;
	psx_cmd_t          push_cmd;
	logic              pop;
	logic              head_valid;
	psx_cmd_t          head_cmd;
	psx_release_t      release_bank;

	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1] == REG_MIN_LENGTH;
	assign prdata  = reg_sel ? {24'd0, min_length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			min_length_q <= pwdata[7:0];
		end
	end

	psx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.min_length   (min_length_q),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.push         (push),
		.cmd          (push_cmd),
		.release_bank (release_bank)
	);

	psx_ram #(
		.WIDTH (7),
		.DEPTH (RAM_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	psx_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	psx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (head_valid),
		.cmd          (head_cmd),
		.pop          (pop),
		.release_bank (release_bank),
		.re           (re),
		.raddr        (raddr),
		.rdata        (rdata),
		.out_ch       (out_ch)
	);
endmodule
`default_nettype wire

[sv/psx_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
// Read data holds while the read enable is low.
`timescale 1ns / 1ps
`default_nettype none
module psx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[sv/psx_front.sv]
// Front end: accepts bytes, tracks the open run, fills the buffer bank, issues string requests.
// Depends on psx_pkg and psx_if.
`timescale 1ns / 1ps
`default_nettype none
module psx_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	psx_in_if.sink                         in_ch,
	input  wire logic [7:0]                min_length,
	output logic                           we,
	output logic [psx_pkg::ADDR_W-1:0]     waddr,
	output logic [6:0]                     wdata,
	output logic                           push,
	output psx_pkg::psx_cmd_t              cmd,
	input  wire psx_pkg::psx_release_t     release_bank
);
	import psx_pkg::*;

	logic             in_run_q;
	logic [RUN_W-1:0] run_len_q;
	logic             bank_q;
	logic [1:0]       busy_q;

	logic             acc;
	logic [7:0]       b;
	logic             printable;
	logic             emit;
	logic             do_append;
	logic [RUN_W-1:0] append_len;
	logic [RUN_W-1:0] next_len;

	assign in_ch.ready = !busy_q[bank_q];
	assign acc         = in_ch.valid && in_ch.ready;
	assign b           = in_ch.data_byte;

	always_comb begin
		printable  = b inside {[8'h20:8'h7E]};
		emit       = (b == NUL_BYTE) && in_run_q && (run_len_q >= RUN_W'(min_length));
		do_append  = printable && (in_run_q || (b != SPACE_BYTE));
		append_len = in_run_q ? run_len_q : '0;
		next_len   = (append_len < RUN_SAT_R) ? append_len + 1'b1 : append_len;
	end

	assign we    = acc && do_append && (append_len < MAX_LEN_R);
	assign waddr = {bank_q, append_len[IDX_W-1:0]};
	assign wdata = b[6:0];

	assign push      = acc && emit;
	assign cmd.bank  = bank_q;
	assign cmd.cnt   = (run_len_q > MAX_LEN_R) ? CNT_W'(MAX_LEN) : run_len_q[CNT_W-1:0];
	assign cmd.trunc = run_len_q > MAX_LEN_R;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q  <= 1'b0;
			run_len_q <= '0;
			bank_q    <= 1'b0;
		end else if (acc) begin
			if (emit || !printable) begin
				in_run_q  <= 1'b0;
				run_len_q <= '0;
			end else if (do_append) begin
				in_run_q  <= 1'b1;
				run_len_q <= next_len;
			end
			if (emit) begin
				bank_q <= !bank_q;
			end
			if (in_ch.section_last) begin
				in_run_q  <= 1'b0;
				run_len_q <= '0;
			end
		end
	end

	// mark a bank busy from its request until the back end has read it out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			if (release_bank.valid) begin
				busy_q[release_bank.bank] <= 1'b0;
			end
			if (push) begin
				busy_q[cmd.bank] <= 1'b1;
			end
		end
	end

	a_push_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !busy_q[cmd.bank])
		else $error("string request on a bank still draining");
	a_write_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !busy_q[waddr[ADDR_W-1]])
		else $error("buffer write into a bank still draining");
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		release_bank.valid |-> busy_q[release_bank.bank])
		else $error("release of a bank that is not busy");
endmodule
`default_nettype wire

[sv/psx_cmd_fifo.sv]
// Two-entry queue of string requests between front and back ends.
// Depends on psx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psx_cmd_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire psx_pkg::psx_cmd_t push_cmd,
	input  wire logic              pop,
	output logic                   head_valid,
	output psx_pkg::psx_cmd_t      head_cmd
);
	import psx_pkg::*;

	psx_cmd_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head_valid = count_q != 2'd0;
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2) || pop)
		else $error("request queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("request queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("request queue count out of range");
endmodule
`default_nettype wire

[sv/psx_back.sv]
// Back end: reads buffered characters of each request and drives the output channel.
// Depends on psx_pkg and psx_if; the buffer RAM read port is registered.
`timescale 1ns / 1ps
`default_nettype none
module psx_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	input  wire psx_pkg::psx_cmd_t     cmd,
	output logic                       pop,
	output psx_pkg::psx_release_t      release_bank,
	output logic                       re,
	output logic [psx_pkg::ADDR_W-1:0] raddr,
	input  wire logic [6:0]            rdata,
	psx_out_if.source                  out_ch
);
	import psx_pkg::*;

	logic [IDX_W-1:0] k_q;
	logic             valid_s1;
	logic             last_s1;
	logic             trunc_s1;
	logic             valid_s2;

	logic adv_s1;
	logic issue;
	logic final_char;

	assign adv_s1     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign issue      = cmd_valid && (!valid_s1 || adv_s1);
	assign final_char = CNT_W'(k_q) == (cmd.cnt - 1'b1);

	assign re    = issue;
	assign raddr = {cmd.bank, k_q};
	assign pop   = issue && final_char;

	assign release_bank.valid = pop;
	assign release_bank.bank  = cmd.bank;

	assign out_ch.valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= final_char ? '0 : k_q + 1'b1;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1  <= final_char;
			trunc_s1 <= final_char && cmd.trunc;
		end
		if (adv_s1) begin
			out_ch.out_char    <= rdata;
			out_ch.string_last <= last_s1;
			out_ch.truncated   <= trunc_s1;
		end
	end

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cmd_valid)
		else $error("request retired with none pending");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("read stage lost a character");
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> CNT_W'(k_q) < cmd.cnt)
		else $error("character index beyond string length");
endmodule
`default_nettype wire
